>>> rtl/core/rhc_pkg.sv
// Shared types and constants for the RGB to HSL converter.
package rhc_pkg;

  localparam int CHANNEL_BITS   = 8;
  localparam int HUE_BITS       = 13;
  localparam int HUE_PER_SECTOR = 960;
  localparam int HUE_FULL_TURN  = 6 * HUE_PER_SECTOR;
  localparam int HUE_Q_BITS     = $clog2(HUE_PER_SECTOR + 1);
  localparam int STEPS          = (HUE_Q_BITS > CHANNEL_BITS) ? HUE_Q_BITS : CHANNEL_BITS;
  localparam int DIV_W          = STEPS + CHANNEL_BITS;

  localparam logic [CHANNEL_BITS-1:0] FULL = '1;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue_out;
    logic [CHANNEL_BITS-1:0] saturation_out;
    logic [CHANNEL_BITS-1:0] lightness_out;
  } hsl_t;

  typedef struct packed {
    logic                    valid;
    logic                    gray;
    sector_t                 sector;
    logic                    neg;
    logic [CHANNEL_BITS-1:0] lightness;
    logic [DIV_W-1:0]        hue_rem;
    logic [DIV_W-1:0]        hue_div;
    logic [STEPS-1:0]        hue_q;
    logic [DIV_W-1:0]        sat_rem;
    logic [DIV_W-1:0]        sat_div;
    logic [STEPS-1:0]        sat_q;
  } cell_data_t;

endpackage

>>> rtl/core/rgb_to_hsl_convert_unit.sv
// Top level of the RGB to HSL converter: input stage, divider cell row, output stage.
// Path: each accepted pixel passes through 12 registers (input stage, 10 division cells,
// output register) on its way to hsl, moving only while not stalled.
// Throughput: one pixel per cycle; the row of division cells moves as one pipeline
// and holds whenever a waiting result is stalled.
// Reset clears every stage valid bit; payload registers are not reset.
module rgb_to_hsl_convert_unit
  import rhc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  input  pixel_t pixel,
  output logic   hsl_valid,
  input  logic   hsl_stall,
  output hsl_t   hsl
);

  logic       go;
  cell_data_t chain [STEPS+1];

  assign go          = !hsl_valid || !hsl_stall;
  assign pixel_stall = !go;

  rhc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .pixel_valid (pixel_valid),
    .pixel       (pixel),
    .data        (chain[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    rhc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .go       (go),
      .data_in  (chain[i]),
      .data_out (chain[i+1])
    );
  end

  rhc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .data      (chain[STEPS]),
    .hsl_valid (hsl_valid),
    .hsl       (hsl)
  );

`ifndef SYNTHESIS
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsl_valid |-> (hsl.hue_out < HUE_BITS'(HUE_FULL_TURN)))
    else $error("hue out of range");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall) |=> chain[0].valid)
    else $error("accepted item did not enter the pipeline");

  a_tail_delivers: assert property (@(posedge clk) disable iff (rst)
    (go && chain[STEPS].valid) |=> hsl_valid)
    else $error("finished item lost before the output register");

  a_gray_result: assert property (@(posedge clk) disable iff (rst)
    (go && chain[STEPS].valid && chain[STEPS].gray) |=>
      (hsl.hue_out == '0 && hsl.saturation_out == '0))
    else $error("gray pixel gave non-zero hue or saturation");
`endif

endmodule

>>> rtl/core/rhc_front.sv
// Input stage: channel extremes, sector choice and divider operands.
module rhc_front
  import rhc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic       pixel_valid,
  input  pixel_t     pixel,
  output cell_data_t data
);

  logic [CHANNEL_BITS-1:0] r, g, b, mx, mn, chroma, den, lhs, rhs, mag;
  logic [CHANNEL_BITS:0]   sum, dev;
  sector_t                 sector;
  cell_data_t              data_next;

  always_comb begin
    r = pixel.red_in;
    g = pixel.green_in;
    b = pixel.blue_in;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = {1'b0, mx} + {1'b0, mn};
    chroma = mx - mn;
    if (sum >= {1'b0, FULL}) begin
      dev = sum - {1'b0, FULL};
    end else begin
      dev = {1'b0, FULL} - sum;
    end
    den = FULL - dev[CHANNEL_BITS-1:0];
    if (r == mx) begin
      sector = SECTOR_RED;
    end else if (g == mx) begin
      sector = SECTOR_GREEN;
    end else begin
      sector = SECTOR_BLUE;
    end
    unique case (sector)
      SECTOR_RED: begin
        lhs = g;
        rhs = b;
      end
      SECTOR_GREEN: begin
        lhs = b;
        rhs = r;
      end
      SECTOR_BLUE: begin
        lhs = r;
        rhs = g;
      end
      default: begin
        lhs = '0;
        rhs = '0;
      end
    endcase
    mag = (lhs < rhs) ? (rhs - lhs) : (lhs - rhs);

    data_next.valid     = pixel_valid && !rst;
    data_next.gray      = (mx == mn);
    data_next.sector    = sector;
    data_next.neg       = (lhs < rhs);
    data_next.lightness = sum[CHANNEL_BITS:1];
    data_next.hue_rem   = DIV_W'(mag) * DIV_W'(HUE_PER_SECTOR);
    data_next.hue_div   = DIV_W'(chroma) << (STEPS - 1);
    data_next.hue_q     = '0;
    data_next.sat_rem   = (DIV_W'(chroma) << CHANNEL_BITS) - DIV_W'(chroma);
    data_next.sat_div   = DIV_W'(den) << (STEPS - 1);
    data_next.sat_q     = '0;
  end

  always_ff @(posedge clk) begin
    if (go || rst) begin
      data <= data_next;
    end
  end

endmodule

>>> rtl/core/rhc_cell.sv
// One restoring division step for both the hue and the saturation quotient.
module rhc_cell
  import rhc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  cell_data_t data_in,
  output cell_data_t data_out
);

  cell_data_t data_next;
  logic       hue_fit, sat_fit;

  always_comb begin
    data_next = data_in;
    hue_fit = (data_in.hue_rem >= data_in.hue_div);
    sat_fit = (data_in.sat_rem >= data_in.sat_div);
    if (hue_fit) data_next.hue_rem = data_in.hue_rem - data_in.hue_div;
    if (sat_fit) data_next.sat_rem = data_in.sat_rem - data_in.sat_div;
    data_next.hue_q   = {data_in.hue_q[STEPS-2:0], hue_fit};
    data_next.sat_q   = {data_in.sat_q[STEPS-2:0], sat_fit};
    data_next.hue_div = data_in.hue_div >> 1;
    data_next.sat_div = data_in.sat_div >> 1;
    data_next.valid   = data_in.valid && !rst;
  end

  always_ff @(posedge clk) begin
    if (go || rst) begin
      data_out <= data_next;
    end
  end

endmodule

>>> rtl/core/rhc_back.sv
// Output stage: sector offset, sign repair and the result register.
module rhc_back
  import rhc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  cell_data_t data,
  output logic       hsl_valid,
  output hsl_t       hsl
);

  logic [HUE_BITS-1:0] q, up, base, hue;
  hsl_t                hsl_next;

  always_comb begin
    q  = HUE_BITS'(data.hue_q);
    up = q + HUE_BITS'(data.hue_rem != '0);
    unique case (data.sector)
      SECTOR_RED:   base = data.neg ? HUE_BITS'(HUE_FULL_TURN) : '0;
      SECTOR_GREEN: base = HUE_BITS'(2 * HUE_PER_SECTOR);
      SECTOR_BLUE:  base = HUE_BITS'(4 * HUE_PER_SECTOR);
      default:      base = '0;
    endcase
    hue = data.neg ? (base - up) : (base + q);
    hsl_next.hue_out        = data.gray ? '0 : hue;
    hsl_next.saturation_out = data.gray ? '0 : data.sat_q[CHANNEL_BITS-1:0];
    hsl_next.lightness_out  = data.lightness;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsl_valid <= 1'b0;
    end else if (go) begin
      hsl_valid <= data.valid;
    end
    if (go) begin
      hsl <= hsl_next;
    end
  end

endmodule
